// ===== hw/rtl/osm_pkg.sv =====
// Shared types and constants for the order statistic multiset.
`default_nettype none
package osm_pkg;

	// Store depth, derived index and count widths, value and rank widths
	localparam int CAPACITY = 256;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;
	localparam int RANK_W   = 9;

	// Request kinds
	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_QUERY  = 1'b1
	} req_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_RANK = 2'd2
	} status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/osm_cell.sv =====
// One storage cell of the sorted chain: holds a value and shifts on insert.
`default_nettype none
module osm_cell (
	input  wire logic                              clk,
	input  wire logic                              ins_en,
	input  wire logic                              occupied,
	input  wire logic signed [osm_pkg::VAL_W-1:0] new_value,
	input  wire logic signed [osm_pkg::VAL_W-1:0] prev_value,
	input  wire logic                              prev_keep,
	output logic signed [osm_pkg::VAL_W-1:0]      cell_value,
	output logic                                   keep
);

	logic signed [osm_pkg::VAL_W-1:0] value_q;
	logic signed [osm_pkg::VAL_W-1:0] value_d;

	// stays put when occupied and not above the new word
	assign keep = occupied && (value_q <= new_value);

	// otherwise take the new word at the boundary, or the neighbour's value
	always_comb begin
		if (keep) begin
			value_d = value_q;
		end else if (prev_keep) begin
			value_d = new_value;
		end else begin
			value_d = prev_value;
		end
	end

	always_ff @(posedge clk) begin
		if (ins_en) begin
			value_q <= value_d;
		end
	end

	assign cell_value = value_q;

endmodule
`default_nettype wire

// ===== hw/rtl/order_statistic_multiset.sv =====
// Top level of the order statistic multiset: request stage, cell chain, result register.
//
// Keeps up to CAPACITY (256) signed 32-bit values in ascending order, duplicates
// allowed, a new value landing after every equal one.
// Command channel: a word (req_type, value, rank) is taken at a rising edge with
// start high and busy low. req_type 0 inserts value; 1 asks for the rank-th
// smallest value, counting from 1.
// Result channel: done is high for exactly one cycle with kth_value and status;
// the receiver cannot stall it and must take it then. status 0 is ok, 1 means the
// store was full and the insert dropped, 2 means rank was zero or above the count.
// kth_value is zero except on a good query.
// Timing: the word is registered on acceptance, the cell chain shifts (or the rank
// select is made) in the following cycle, and done rises the cycle after that.
// busy is high for the one cycle in which the chain works, so a new word is not
// taken while the chain works on the last one; all cells shift in parallel.
// Reset (arst_n low) empties the store at once; no clearing sweep is needed, as
// cells past the count are never read.
`default_nettype none
module order_statistic_multiset (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic                               req_type,
	input  wire logic signed [osm_pkg::VAL_W-1:0]  value,
	input  wire logic [osm_pkg::RANK_W-1:0]        rank,
	output logic                                    done,
	output logic signed [osm_pkg::VAL_W-1:0]       kth_value,
	output logic [1:0]                              status
);

	// request stage
	logic                              req_valid_s1;
	osm_pkg::req_t                     req_type_s1;
	logic signed [osm_pkg::VAL_W-1:0] value_s1;
	logic [osm_pkg::RANK_W-1:0]       rank_s1;

	// store fill and result registers
	logic [osm_pkg::CNT_W-1:0]        count_q;
	logic                              done_q;
	logic signed [osm_pkg::VAL_W-1:0] kth_value_q;
	osm_pkg::status_t                  status_q;

	// chain wiring
	logic signed [osm_pkg::VAL_W-1:0] cell_value [osm_pkg::CAPACITY];
	logic                              cell_keep  [osm_pkg::CAPACITY];

	logic                              accept;
	logic                              is_full;
	logic                              rank_bad;
	logic                              ins_en;
	logic [osm_pkg::IDX_W-1:0]        sel_idx;
	logic [osm_pkg::RANK_W-1:0]       rank_m1;

	assign accept = start && !busy;
	assign busy   = req_valid_s1;

	// capture the command word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else begin
			req_valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_s1 <= osm_pkg::req_t'(req_type);
			value_s1    <= value;
			rank_s1     <= rank;
		end
	end

	// request decode
	assign is_full  = (count_q == osm_pkg::CNT_W'(osm_pkg::CAPACITY));
	assign rank_bad = (rank_s1 == '0) || (32'(rank_s1) > 32'(count_q))
		|| (32'(rank_s1) > 32'(osm_pkg::CAPACITY));
	assign ins_en   = req_valid_s1 && (req_type_s1 == osm_pkg::REQ_INSERT) && !is_full;
	assign rank_m1  = rank_s1 - osm_pkg::RANK_W'(1);
	assign sel_idx  = rank_m1[osm_pkg::IDX_W-1:0];

	// row of cells, each handing its value and keep flag to the next
	for (genvar gi = 0; gi < osm_pkg::CAPACITY; gi++) begin : g_cell
		logic signed [osm_pkg::VAL_W-1:0] prev_value;
		logic                              prev_keep;
		logic                              occupied;

		if (gi == 0) begin : g_head
			assign prev_value = value_s1;
			assign prev_keep  = 1'b1;
		end else begin : g_body
			assign prev_value = cell_value[gi-1];
			assign prev_keep  = cell_keep[gi-1];
		end

		assign occupied = (osm_pkg::CNT_W'(gi) < count_q);

		osm_cell u_cell (
			.clk        (clk),
			.ins_en     (ins_en),
			.occupied   (occupied),
			.new_value  (value_s1),
			.prev_value (prev_value),
			.prev_keep  (prev_keep),
			.cell_value (cell_value[gi]),
			.keep       (cell_keep[gi])
		);
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ins_en) begin
			count_q <= count_q + osm_pkg::CNT_W'(1);
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= req_valid_s1;
		end
	end

	// result payload: rank select or status only
	always_ff @(posedge clk) begin
		if (req_valid_s1) begin
			kth_value_q <= '0;
			status_q    <= osm_pkg::ST_OK;
			case (req_type_s1)
				osm_pkg::REQ_INSERT: begin
					if (is_full) begin
						status_q <= osm_pkg::ST_FULL;
					end
				end
				osm_pkg::REQ_QUERY: begin
					if (rank_bad) begin
						status_q <= osm_pkg::ST_RANK;
					end else begin
						kth_value_q <= cell_value[sel_idx];
					end
				end
				default: begin
					status_q <= osm_pkg::ST_OK;
				end
			endcase
		end
	end

	assign done      = done_q;
	assign kth_value = kth_value_q;
	assign status    = status_q;

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the order statistic multiset: inserts and k-th smallest queries.
`timescale 1ns / 1ps

module tb;
	import osm_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic signed [VAL_W-1:0] kth;
		status_t                 st;
	} result_t;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic                     req_type;
	logic signed [VAL_W-1:0]  value;
	logic [RANK_W-1:0]        rank;
	logic                     done;
	logic signed [VAL_W-1:0]  kth_value;
	logic [1:0]               status;

	// Shadow copy of the sorted store
	logic signed [VAL_W-1:0]  shadow_sorted [CAPACITY];
	int                       shadow_count;

	// Results still owed by the block, oldest first
	result_t                  owed_results[$];

	int                       idle_pct;
	int                       error_count;
	int                       cycle_count;
	int                       checked_count;
	int                       n_insert, n_full, n_query, n_rank_err;

	order_statistic_multiset uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req_type  (req_type),
		.value     (value),
		.rank      (rank),
		.done      (done),
		.kth_value (kth_value),
		.status    (status)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Run guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	// Works out the result of one word and updates the shadow store
	function automatic result_t apply_request(input req_t kind,
			input logic signed [VAL_W-1:0] val, input logic [RANK_W-1:0] rk);
		result_t r;
		int      pos;
		int      i;
		r.kth = '0;
		r.st  = ST_OK;
		if (kind == REQ_INSERT) begin
			if (shadow_count >= CAPACITY) begin
				r.st = ST_FULL;
			end else begin
				// new value lands after every equal one
				pos = 0;
				while (pos < shadow_count && shadow_sorted[pos] <= val)
					pos++;
				for (i = shadow_count; i > pos; i--)
					shadow_sorted[i] = shadow_sorted[i-1];
				shadow_sorted[pos] = val;
				shadow_count++;
			end
		end else if (rk == '0 || int'(rk) > shadow_count) begin
			r.st = ST_RANK;
		end else begin
			r.kth = shadow_sorted[int'(rk) - 1];
		end
		return r;
	endfunction

	// Compare each result word with the oldest one owed
	always @(posedge clk) begin : check_result
		result_t due;
		if (arst_n && done) begin
			checked_count++;
			if (owed_results.size() == 0) begin
				report_mismatch($sformatf("result word with none owed: kth %0d status %0d",
					kth_value, status));
			end else begin
				due = owed_results.pop_front();
				if (kth_value !== due.kth)
					report_mismatch($sformatf("kth_value %0d, wanted %0d", kth_value, due.kth));
				if (status !== due.st)
					report_mismatch($sformatf("status %0d, wanted %0d", status, due.st));
			end
		end
	end

	// Offers one word, waits for it to be taken, then idles at random
	task automatic send_word(input req_t kind, input logic signed [VAL_W-1:0] val,
			input logic [RANK_W-1:0] rk);
		result_t r;
		int      gap;
		start    <= 1'b1;
		req_type <= kind;
		value    <= val;
		rank     <= rk;
		do @(posedge clk); while (busy !== 1'b0);
		r = apply_request(kind, val, rk);
		owed_results.push_back(r);
		if (kind == REQ_INSERT) begin
			n_insert++;
			if (r.st == ST_FULL) n_full++;
		end else begin
			n_query++;
			if (r.st == ST_RANK) n_rank_err++;
		end
		gap = 0;
		while ($urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			// noise on the fields while start is low
			start    <= 1'b0;
			req_type <= 1'($urandom_range(1));
			value    <= $urandom;
			rank     <= RANK_W'($urandom_range(511));
			repeat (gap) @(posedge clk);
		end
	endtask

	// Sender holds off until every owed result has come back
	task automatic settle();
		start <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic signed [VAL_W-1:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 30)
			return int'($urandom_range(8)) - 4;
		if (r < 45) begin
			case ($urandom_range(5))
				0: return 32'sh8000_0000;
				1: return 32'sh7FFF_FFFF;
				2: return 32'sh8000_0001;
				3: return 32'sh7FFF_FFFE;
				4: return -1;
				default: return 0;
			endcase
		end
		if (r < 55 && shadow_count > 0)
			return shadow_sorted[$urandom_range(shadow_count - 1)];
		return $urandom;
	endfunction

	function automatic logic [RANK_W-1:0] pick_rank();
		int r;
		r = $urandom_range(99);
		if (r < 70 && shadow_count > 0)
			return RANK_W'($urandom_range(shadow_count, 1));
		if (r < 78)
			return '0;
		if (r < 86)
			return RANK_W'(shadow_count + 1);
		if (r < 93)
			return $urandom_range(1) ? 9'd256 : 9'd511;
		return RANK_W'($urandom_range(511));
	endfunction

	task automatic test_empty_queries();
		send_word(REQ_QUERY, $urandom, 9'd0);
		send_word(REQ_QUERY, $urandom, 9'd1);
		send_word(REQ_QUERY, $urandom, 9'd256);
		send_word(REQ_QUERY, $urandom, 9'd511);
	endtask

	task automatic test_extreme_values();
		send_word(REQ_INSERT, 32'sh7FFF_FFFF, RANK_W'($urandom_range(511)));
		send_word(REQ_INSERT, 32'sh8000_0000, RANK_W'($urandom_range(511)));
		send_word(REQ_INSERT, 0, 9'd0);
		send_word(REQ_INSERT, -1, 9'd511);
		send_word(REQ_INSERT, 32'sh7FFF_FFFF, 9'd1);
		send_word(REQ_INSERT, 32'sh8000_0000, 9'd256);
		send_word(REQ_INSERT, 0, RANK_W'($urandom_range(511)));
		send_word(REQ_QUERY, $urandom, 9'd1);
		send_word(REQ_QUERY, $urandom, 9'd2);
		send_word(REQ_QUERY, $urandom, 9'd4);
		send_word(REQ_QUERY, 32'sh7FFF_FFFF, 9'd7);
		send_word(REQ_QUERY, $urandom, 9'd8);
		send_word(REQ_QUERY, $urandom, 9'd0);
		send_word(REQ_QUERY, 32'sh8000_0000, 9'd511);
		send_word(REQ_INSERT, 1, 9'h1FF);
		send_word(REQ_QUERY, $urandom, 9'd6);
	endtask

	// Mostly queries against a slowly growing store
	task automatic test_random_mix(input int pct, input int words, input int insert_pct);
		idle_pct = pct;
		repeat (words) begin
			if ($urandom_range(99) < insert_pct)
				send_word(REQ_INSERT, pick_value(), RANK_W'($urandom_range(511)));
			else
				send_word(REQ_QUERY, $urandom, pick_rank());
		end
		idle_pct = 0;
	endtask

	// Fill up, overflow, then query right to the top rank
	task automatic test_fill_to_capacity();
		idle_pct = 18;
		while (shadow_count < CAPACITY) begin
			if ($urandom_range(99) < 75)
				send_word(REQ_INSERT, pick_value(), RANK_W'($urandom_range(511)));
			else
				send_word(REQ_QUERY, $urandom, pick_rank());
		end
		repeat (24) send_word(REQ_INSERT, pick_value(), RANK_W'($urandom_range(511)));
		send_word(REQ_QUERY, $urandom, 9'd256);
		send_word(REQ_QUERY, $urandom, 9'd257);
		send_word(REQ_QUERY, $urandom, 9'd511);
		send_word(REQ_QUERY, $urandom, 9'd1);
		send_word(REQ_QUERY, $urandom, 9'd0);
		repeat (80) begin
			if ($urandom_range(99) < 15)
				send_word(REQ_INSERT, pick_value(), RANK_W'($urandom_range(511)));
			else
				send_word(REQ_QUERY, $urandom, pick_rank());
		end
		idle_pct = 0;
	endtask

	initial begin
		arst_n        <= 1'b0;
		start         <= 1'b0;
		req_type      <= 1'b0;
		value         <= '0;
		rank          <= '0;
		idle_pct      = 0;
		error_count   = 0;
		cycle_count   = 0;
		checked_count = 0;
		shadow_count  = 0;
		n_insert      = 0;
		n_full        = 0;
		n_query       = 0;
		n_rank_err    = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_queries();
		test_extreme_values();
		settle();
		test_random_mix(0, 450, 12);
		settle();
		test_random_mix(85, 450, 12);
		test_random_mix(18, 450, 12);
		settle();
		test_fill_to_capacity();
		settle();

		$display("Run covered %0d inserts (%0d dropped on a full store) and %0d queries",
			n_insert, n_full, n_query);
		$display("(%0d with a bad rank); %0d result words checked, %0d mismatches",
			n_rank_err, checked_count, error_count);
		if (error_count == 0 && owed_results.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== order_statistic_multiset.f =====
hw/rtl/osm_pkg.sv
hw/rtl/osm_cell.sv
hw/rtl/order_statistic_multiset.sv
tb/tb.sv
